/* sv/pftj_pkg.sv */
package pftj_pkg;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        R_TARGET_FORCE  = 3'd0,
        R_TARGET_GAIN_P = 3'd1,
        R_TARGET_GAIN_I = 3'd2,
        R_FILTER_COEF   = 3'd3,
        R_RATE_LIMIT    = 3'd4,
        R_FORCE_OFFSET  = 3'd5
    } t_reg_idx;

    // Sequencer phases. Multiplies run on the shared bit-serial unit.
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MUL_INC,
        S_MUL_TI,
        S_MUL_TP,
        S_CMD,
        S_MUL_FD,
        S_MUL_FP,
        S_MUL_FI,
        S_MUL_TQ,
        S_LIMIT,
        S_OUT
    } t_state;

    // Multiplier request: operands as magnitude plus sign
    typedef struct packed {
        logic        start;
        logic [47:0] mag_a;
        logic [47:0] mag_b;
        logic        neg;
        logic [5:0]  shift;
    } t_mul_req;

endpackage

/* sv/pftj_mul.sv */
// Shift-add multiplier: one bit of B per cycle, then rounding and saturation.
module pftj_mul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pftj_pkg::t_mul_req    i_req,
    input  logic [63:0]           i_lim,
    output logic                  o_done,
    output logic signed [64:0]    o_result
);
    logic [95:0] r_acc, n_acc;
    logic [47:0] r_a, r_b;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, r_neg, r_done;
    logic [5:0]  r_shift;
    logic [95:0] w_rnd, w_q;
    logic [64:0] w_max, w_mag;

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (r_busy) begin
            if (r_b[r_cnt[5:0]]) begin
                n_acc = r_acc + ({48'd0, r_a} << r_cnt[5:0]);
            end
            n_cnt = r_cnt + 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 7'd47) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_acc   <= '0;
            r_cnt   <= '0;
            r_a     <= i_req.mag_a;
            r_b     <= i_req.mag_b;
            r_neg   <= i_req.neg;
            r_shift <= i_req.shift;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    always_comb begin
        w_rnd = r_acc + (96'd1 << (r_shift - 6'd1));
        w_q   = w_rnd >> r_shift;
        w_max = r_neg ? ({1'b0, i_lim} + 65'd1) : {1'b0, i_lim};
        w_mag = (w_q[95:64] != '0 || {1'b0, w_q[63:0]} > w_max) ? w_max
                : {1'b0, w_q[63:0]};
        o_result = r_neg ? -$signed(w_mag) : $signed(w_mag);
    end
    assign o_done = r_done;
endmodule

/* sv/pi_force_to_joint_torque_core.sv */
// From input transfer to result valid, an ordinary item takes one serial multiply
// plus the limit and output steps, and a first-of-tick item takes seven serial
// multiplies plus the error, command, limit and output steps.
// One item at a time: the next input transfer can come as early as the cycle in
// which the result becomes valid, later while an untaken result holds the output
// register.
// Reset (synchronous, active low) clears the loop state and loads register
// defaults.
module pi_force_to_joint_torque_core #(
    parameter int NUM_JOINTS  = 7,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_first_of_tick,
    input  logic [2:0]                    i_joint_number,
    input  logic [23:0]                   i_step_time,
    input  logic signed [VALUE_WIDTH-1:0] i_measured_force,
    input  logic signed [VALUE_WIDTH-1:0] i_jacobian_z,
    input  logic signed [VALUE_WIDTH-1:0] i_measured_torque,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_joint_out,
    output logic signed [VALUE_WIDTH-1:0] o_torque_command,
    output logic                          o_last_joint,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pftj_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int VW = VALUE_WIDTH;
    localparam logic signed [64:0] VLIM = 65'sd2**(VW-1) - 65'sd1;
    localparam logic signed [64:0] ILIM = 65'sd2**47 - 65'sd1;
    localparam logic signed [64:0] FLIM = 65'sd2**50;
    localparam logic [2:0] LAST_J = 3'(NUM_JOINTS - 1);

    logic signed [31:0] r_tgt_f, r_tgt_p, r_tgt_i, r_offset;
    logic [16:0]        r_coef;
    logic [30:0]        r_rlim;
    logic signed [47:0] r_integ;
    logic signed [VW-1:0] r_des, r_gp, r_gi, r_fcmd;

    logic signed [VW-1:0] r_jz, r_tmeas, r_fmeas;
    logic [23:0]          r_dt;
    logic [2:0]           r_joint;
    logic                 r_first;
    logic signed [VW-1:0] r_err, r_ti;
    logic signed [64:0]   r_tmp;

    logic                 r_ovalid;
    logic [2:0]           r_ojoint;
    logic signed [VW-1:0] r_otq;
    logic                 r_olast;

    pftj_pkg::t_state r_state, n_state;
    logic             r_issued;
    pftj_pkg::t_mul_req w_req;
    logic [63:0]      w_lim;
    logic             w_done;
    logic signed [64:0] w_mres;
    logic             w_wr;
    logic [2:0]       w_idx;
    logic [16:0]      w_c;

    function automatic logic signed [64:0] sat65(input logic signed [64:0] x,
                                                 input logic signed [64:0] l);
        logic signed [64:0] r;
        begin
            r = x;
            if (x > l) r = l;
            if (x < -l - 65'sd1) r = -l - 65'sd1;
            return r;
        end
    endfunction

    function automatic logic [47:0] mag65(input logic signed [64:0] x);
        logic signed [64:0] m;
        begin
            m = (x < 0) ? -x : x;
            return m[47:0];
        end
    endfunction

    // configuration
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[4:2];
    always_comb begin
        case (w_idx)
            pftj_pkg::R_TARGET_FORCE:  prdata = r_tgt_f;
            pftj_pkg::R_TARGET_GAIN_P: prdata = r_tgt_p;
            pftj_pkg::R_TARGET_GAIN_I: prdata = r_tgt_i;
            pftj_pkg::R_FILTER_COEF:   prdata = {15'd0, r_coef};
            pftj_pkg::R_RATE_LIMIT:    prdata = {1'b0, r_rlim};
            pftj_pkg::R_FORCE_OFFSET:  prdata = r_offset;
            default:                   prdata = '0;
        endcase
    end

    assign w_c = (r_coef > 17'd65536) ? 17'd65536 : r_coef;

    pftj_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_lim(w_lim),
        .o_done(w_done), .o_result(w_mres)
    );

    // operand select per phase
    always_comb begin
        w_req       = '0;
        w_req.start = !r_issued;
        w_req.shift = 6'd16;
        w_lim       = VLIM[63:0];
        case (r_state)
            pftj_pkg::S_MUL_INC: begin
                w_req.mag_a = mag65(65'(r_err));
                w_req.mag_b = {24'd0, r_dt};
                w_req.neg   = r_err < 0 && r_dt != '0;
                w_req.shift = 6'd24;
                w_lim       = ILIM[63:0];
            end
            pftj_pkg::S_MUL_TI: begin
                w_req.mag_a = mag65(65'(r_gi));
                w_req.mag_b = mag65(65'(r_integ));
                w_req.neg   = (r_gi < 0) != (r_integ < 0);
            end
            pftj_pkg::S_MUL_TP: begin
                w_req.mag_a = mag65(65'(r_gp));
                w_req.mag_b = mag65(65'(r_err));
                w_req.neg   = (r_gp < 0) != (r_err < 0);
            end
            pftj_pkg::S_MUL_FD, pftj_pkg::S_MUL_FP, pftj_pkg::S_MUL_FI: begin
                w_req.mag_a = {31'd0, w_c};
                w_req.mag_b = mag65(r_tmp);
                w_req.neg   = w_c != '0 && r_tmp < 0;
                w_lim       = FLIM[63:0];
            end
            pftj_pkg::S_MUL_TQ: begin
                w_req.mag_a = mag65(65'(r_jz));
                w_req.mag_b = mag65(65'(r_fcmd));
                w_req.neg   = (r_jz < 0) != (r_fcmd < 0);
            end
            default: w_req.start = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pftj_pkg::S_IDLE:
                if (i_valid && o_ready)
                    n_state = i_first_of_tick ? pftj_pkg::S_ERR : pftj_pkg::S_MUL_TQ;
            pftj_pkg::S_ERR:     n_state = pftj_pkg::S_MUL_INC;
            pftj_pkg::S_MUL_INC: if (w_done) n_state = pftj_pkg::S_MUL_TI;
            pftj_pkg::S_MUL_TI:  if (w_done) n_state = pftj_pkg::S_MUL_TP;
            pftj_pkg::S_MUL_TP:  if (w_done) n_state = pftj_pkg::S_CMD;
            pftj_pkg::S_CMD:     n_state = pftj_pkg::S_MUL_FD;
            pftj_pkg::S_MUL_FD:  if (w_done) n_state = pftj_pkg::S_MUL_FP;
            pftj_pkg::S_MUL_FP:  if (w_done) n_state = pftj_pkg::S_MUL_FI;
            pftj_pkg::S_MUL_FI:  if (w_done) n_state = pftj_pkg::S_MUL_TQ;
            pftj_pkg::S_MUL_TQ:  if (w_done) n_state = pftj_pkg::S_LIMIT;
            pftj_pkg::S_LIMIT:   n_state = pftj_pkg::S_OUT;
            pftj_pkg::S_OUT:     if (!r_ovalid) n_state = pftj_pkg::S_IDLE;
            default:             n_state = pftj_pkg::S_IDLE;
        endcase
    end

    assign o_ready = (r_state == pftj_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pftj_pkg::S_IDLE;
            r_issued <= 1'b1;
            r_ovalid <= 1'b0;
            r_tgt_f  <= '0;
            r_tgt_p  <= '0;
            r_tgt_i  <= '0;
            r_coef   <= 17'd655;
            r_rlim   <= 31'd65536;
            r_offset <= '0;
            r_integ  <= '0;
            r_des    <= '0;
            r_gp     <= '0;
            r_gi     <= '0;
            r_fcmd   <= '0;
        end else begin
            r_state <= n_state;
            if (n_state != r_state) r_issued <= 1'b0;
            else if (w_req.start)   r_issued <= 1'b1;
            if (o_valid && i_ready) r_ovalid <= 1'b0;

            if (w_wr) begin
                case (w_idx)
                    pftj_pkg::R_TARGET_FORCE:  r_tgt_f  <= pwdata;
                    pftj_pkg::R_TARGET_GAIN_P: r_tgt_p  <= pwdata;
                    pftj_pkg::R_TARGET_GAIN_I: r_tgt_i  <= pwdata;
                    pftj_pkg::R_FILTER_COEF:   r_coef   <= pwdata[16:0];
                    pftj_pkg::R_RATE_LIMIT:    r_rlim   <= pwdata[30:0];
                    pftj_pkg::R_FORCE_OFFSET:  r_offset <= pwdata;
                    default: ;
                endcase
            end

            case (r_state)
                pftj_pkg::S_IDLE: if (i_valid && o_ready) begin
                    r_jz    <= i_jacobian_z;
                    r_tmeas <= i_measured_torque;
                    r_fmeas <= i_measured_force;
                    r_dt    <= i_step_time;
                    r_joint <= i_joint_number;
                    r_first <= i_first_of_tick;
                end
                pftj_pkg::S_ERR: begin
                    r_tmp <= sat65(-65'(r_des) - 65'(r_fmeas) + 65'(r_offset), VLIM);
                    r_err <= VW'(sat65(-65'(r_des) - 65'(r_fmeas) + 65'(r_offset), VLIM));
                end
                pftj_pkg::S_MUL_INC: if (w_done)
                    r_integ <= 48'(sat65(65'(r_integ) + w_mres, ILIM));
                pftj_pkg::S_MUL_TI: if (w_done) r_ti <= VW'(w_mres);
                pftj_pkg::S_MUL_TP: if (w_done) begin
                    r_fcmd <= VW'(sat65(-65'(r_des) + 65'(r_ti) + w_mres, VLIM));
                end
                pftj_pkg::S_CMD: r_tmp <= 65'(r_tgt_f) - 65'(r_des);
                pftj_pkg::S_MUL_FD: if (w_done) begin
                    r_des <= VW'(sat65(65'(r_des) + w_mres, VLIM));
                    r_tmp <= 65'(r_tgt_p) - 65'(r_gp);
                end
                pftj_pkg::S_MUL_FP: if (w_done) begin
                    r_gp  <= VW'(sat65(65'(r_gp) + w_mres, VLIM));
                    r_tmp <= 65'(r_tgt_i) - 65'(r_gi);
                end
                pftj_pkg::S_MUL_FI: if (w_done)
                    r_gi <= VW'(sat65(65'(r_gi) + w_mres, VLIM));
                pftj_pkg::S_MUL_TQ: if (w_done)
                    r_tmp <= w_mres - 65'(r_tmeas);
                pftj_pkg::S_LIMIT: begin
                    if (r_tmp > $signed(65'(r_rlim)))
                        r_tmp <= $signed(65'(r_rlim));
                    else if (r_tmp < -$signed(65'(r_rlim)))
                        r_tmp <= -$signed(65'(r_rlim));
                end
                pftj_pkg::S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    r_ojoint <= r_joint;
                    r_olast  <= (r_joint == LAST_J);
                    r_otq    <= VW'(sat65(65'(r_tmeas) + r_tmp, VLIM));
                end
                default: ;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_joint_out      = r_ojoint;
    assign o_torque_command = r_otq;
    assign o_last_joint     = r_olast;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == pftj_pkg::S_IDLE)
        else $error("ready outside idle");
    a_tick_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pftj_pkg::S_ERR) |-> r_first)
        else $error("force loop without first item");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_torque_command))
        else $error("result dropped");
endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AW = pftj_pkg::ADDR_W;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint IMAX = (64'sd1 <<< 47) - 1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_first_of_tick = 1'b0;
    logic [2:0]  i_joint_number = '0;
    logic [23:0] i_step_time = '0;
    logic signed [31:0] i_measured_force = '0;
    logic signed [31:0] i_jacobian_z = '0;
    logic signed [31:0] i_measured_torque = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_joint_out;
    logic signed [31:0] o_torque_command;
    logic        o_last_joint;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors = 0;
    int n_in = 0;
    int n_out = 0;
    int send_idle = 0;
    int recv_idle = 0;

    pi_force_to_joint_torque_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    typedef struct {
        logic [2:0]  joint;
        logic [31:0] torque;
        logic        last;
    } t_torque_res;

    // rounded (a*b)>>s, ties away from zero, saturated to [-lim-1, lim]
    function automatic longint mul_round(longint a, longint b, int s, longint lim);
        logic        neg;
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0] ma, mb, mx;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ma * mb;
        q = (p + (128'd1 << (s - 1))) >> s;
        mx = neg ? lim + 1 : lim;
        if (q > mx) q = mx;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip(longint x, longint lim);
        if (x > lim) return lim;
        if (x < -lim - 1) return -lim - 1;
        return x;
    endfunction

    class torque_scoreboard;
        longint tgt_force, tgt_kp, tgt_ki, coef, rate_lim, offset;
        longint integral, des_now, kp_now, ki_now, f_cmd;
        t_torque_res pending[$];

        function new();
            tgt_force = 0; tgt_kp = 0; tgt_ki = 0;
            coef = 655; rate_lim = 65536; offset = 0;
            integral = 0; des_now = 0; kp_now = 0; ki_now = 0; f_cmd = 0;
        endfunction

        function void set_reg(pftj_pkg::t_reg_idx idx, logic [31:0] v);
            case (idx)
                pftj_pkg::R_TARGET_FORCE:  tgt_force = longint'(signed'(v));
                pftj_pkg::R_TARGET_GAIN_P: tgt_kp = longint'(signed'(v));
                pftj_pkg::R_TARGET_GAIN_I: tgt_ki = longint'(signed'(v));
                pftj_pkg::R_FILTER_COEF:   coef = v[16:0];
                pftj_pkg::R_RATE_LIMIT:    rate_lim = v[30:0];
                pftj_pkg::R_FORCE_OFFSET:  offset = longint'(signed'(v));
                default: ;
            endcase
        endfunction

        function longint smooth(longint now, longint tgt, longint c);
            return clip(now + mul_round(c, tgt - now, 16, 64'sd1 <<< 50), VMAX);
        endfunction

        function void note_input(logic first, logic [2:0] jn, logic [23:0] dt,
                                 logic signed [31:0] fm, logic signed [31:0] jz,
                                 logic signed [31:0] tm);
            longint err, ti, tp, c, torque, diff, neg_des;
            t_torque_res r;
            if (first) begin
                neg_des = -des_now;
                err = clip(neg_des - longint'(fm) + offset, VMAX);
                integral = clip(integral + mul_round(err, longint'(dt), 24, IMAX), IMAX);
                ti = mul_round(ki_now, integral, 16, VMAX);
                tp = mul_round(kp_now, err, 16, VMAX);
                f_cmd = clip(neg_des + ti + tp, VMAX);
                c = coef > 65536 ? 65536 : coef;
                des_now = smooth(des_now, tgt_force, c);
                kp_now = smooth(kp_now, tgt_kp, c);
                ki_now = smooth(ki_now, tgt_ki, c);
            end
            torque = mul_round(longint'(jz), f_cmd, 16, VMAX);
            diff = torque - longint'(tm);
            if (diff > rate_lim) diff = rate_lim;
            if (diff < -rate_lim) diff = -rate_lim;
            r.joint = jn;
            r.torque = clip(longint'(tm) + diff, VMAX);
            r.last = (jn == 3'd6);
            pending = {pending, r};
        endfunction

        task check_result(logic [2:0] jn, logic [31:0] tq, logic last);
            t_torque_res e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result joint %0d", jn));
                return;
            end
            e = pending.pop_front();
            if (jn !== e.joint)
                report($sformatf("joint_out %0d, want %0d", jn, e.joint));
            if (tq !== e.torque)
                report($sformatf("torque %h, want %h (joint %0d)", tq, e.torque, e.joint));
            if (last !== e.last)
                report($sformatf("last_joint %b, want %b", last, e.last));
        endtask
    endclass

    torque_scoreboard sb = new();

    // output side
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_joint_out, o_torque_command, o_last_joint);
            n_out++;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic reg_write(pftj_pkg::t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= AW'(4 * int'(idx)); pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // valid stays up after a transfer until the next item or idle cycle replaces it
    task automatic send_item(logic first, logic [2:0] jn, logic [23:0] dt,
                             logic [31:0] fm, logic [31:0] jz, logic [31:0] tm);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_of_tick <= first; i_joint_number <= jn; i_step_time <= dt;
        i_measured_force <= fm; i_jacobian_z <= jz; i_measured_torque <= tm;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(first, jn, dt, fm, jz, tm);
        n_in++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(262143) - 131072;
            3: return $urandom_range(16777215) - 8388608;
            default: return $urandom;
        endcase
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic random_tick();
        logic [2:0] j;
        for (int k = 0; k < 7; k++) begin
            j = 3'(k);
            if ($urandom_range(19) == 0) j = 3'($urandom_range(7));
            send_item(k == 0 ? ($urandom_range(15) != 0) : ($urandom_range(30) == 0), j,
                      $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(40000)),
                      rnd_val(), rnd_val(), rnd_val());
        end
    endtask

    task automatic random_config(int mode);
        reg_write(pftj_pkg::R_TARGET_FORCE, rnd_val());
        reg_write(pftj_pkg::R_TARGET_GAIN_P, mode == 0 ? 32'h7FFFFFFF : rnd_val());
        reg_write(pftj_pkg::R_TARGET_GAIN_I, mode == 0 ? 32'h80000000 : rnd_val());
        reg_write(pftj_pkg::R_FILTER_COEF, mode == 0 ? 32'h1FFFF : (mode == 1 ? 32'd0 :
                  32'($urandom_range(70000))));
        reg_write(pftj_pkg::R_RATE_LIMIT,
                  mode == 0 ? 32'h7FFFFFFF : (mode == 1 ? 32'd0 : rnd_val()));
        reg_write(pftj_pkg::R_FORCE_OFFSET, rnd_val());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 25; recv_idle = 50;

        // items before any tick start, then the extremes
        send_item(1'b0, 3'd3, 24'd0, 32'h0, 32'h7FFFFFFF, 32'h0);
        drain();
        reg_write(pftj_pkg::R_TARGET_FORCE, 32'h000A0000);
        reg_write(pftj_pkg::R_TARGET_GAIN_P, 32'h00010000);
        reg_write(pftj_pkg::R_TARGET_GAIN_I, 32'h00008000);
        reg_write(pftj_pkg::R_FILTER_COEF, 32'd65536);
        reg_write(pftj_pkg::R_FORCE_OFFSET, 32'hFFFF0000);
        for (int k = 0; k < 7; k++)
            send_item(k == 0, 3'(k), 24'hFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        for (int k = 0; k < 7; k++)
            send_item(k == 0, 3'(k), 24'd16777, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_item(1'b1, 3'd4, 24'd1000, 32'h00050000, 32'h00010000, 32'h0);  // late tick start
        send_item(1'b0, 3'd7, 24'd0, 32'h0, 32'hFFFF0000, 32'h00001234);     // joint out of range
        send_item(1'b0, 3'd6, 24'hFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin send_idle = 50; recv_idle = 25; end
            if (ph == 8) begin send_idle = 0; recv_idle = 0; end
            random_config(ph % 4);
            for (int t = 0; t < 14; t++) random_tick();
            drain();
        end
        $display("Covered %0d items and %0d results over 12 register settings,", n_in, n_out);
        $display("including gain, filter and rate-limit extremes and odd tick markers.");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("testbench NOT OK");
        $finish;
    end
endmodule
